>>> rtl/lz78e_pkg.sv
`timescale 1ns / 1ps

package lz78e_pkg;

    localparam int DICT_NODES = 4096;
    localparam int ALPHABET   = 28;
    localparam int SLOT_SPACE = 26;
    localparam int SLOT_END   = 27;
    localparam int TABLE_SIZE = DICT_NODES * ALPHABET;

    localparam int NODE_W = $clog2(DICT_NODES);
    localparam int NEXT_W = $clog2(DICT_NODES + 1);
    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int SLOT_W = $clog2(ALPHABET);

    localparam int PREFIX_W = 12;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_END   = 8'h24;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } enc_state_t;

    typedef struct packed {
        logic              slot_bad;
        logic [SLOT_W-1:0] slot;
    } slot_info_t;

    // One access per cycle: either a lookup read or a node store.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [NODE_W-1:0] wr_data;
    } mem_req_t;

    function automatic slot_info_t slot_of(input logic [BYTE_W-1:0] b);
        slot_info_t info;
        info.slot_bad = 1'b0;
        info.slot     = '0;
        if (b == CHAR_SPACE)
        begin
            info.slot = SLOT_W'(SLOT_SPACE);
        end
        else if (b == CHAR_END)
        begin
            info.slot = SLOT_W'(SLOT_END);
        end
        else if (b < CHAR_LOW_A || b > CHAR_LOW_Z)
        begin
            info.slot_bad = 1'b1;
        end
        else
        begin
            info.slot = SLOT_W'(b - CHAR_LOW_A);
        end
        return info;
    endfunction

endpackage

>>> rtl/lz78e_child_table.sv
`timescale 1ns / 1ps

module lz78e_child_table
    import lz78e_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [NODE_W-1:0] rd_data,
    output logic              ready
);

    logic [NODE_W-1:0] mem [TABLE_SIZE];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [NODE_W-1:0] rd_data_reg;

    assign ready   = !clr_busy_reg;
    assign rd_data = rd_data_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(TABLE_SIZE - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

`ifndef SYNTHESIS
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !(req.rd_en || req.wr_en))
        else $error("child table accessed during clearing pass");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("child table read and write in the same cycle");

    a_clear_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == ADDR_W'(TABLE_SIZE - 1))
        else $error("clearing pass ended early");
`endif

endmodule

>>> rtl/lz78_phrase_encoder.sv
`timescale 1ns / 1ps

// LZ78 phrase encoder, 28-symbol alphabet (a-z, space, '$'). After reset the
// child table is swept to zero, one entry a cycle. busy stays high through
// that sweep and until the state machine, seeing the table ready, leaves
// ST_CLEAR, and requests are not taken during that time. Afterwards each byte
// passes through ST_IDLE, which issues the registered child-table read when
// start is accepted, then ST_LOOKUP, which decides hit or miss and, unless the
// dictionary is full, stores the new node. busy is high in ST_LOOKUP. A miss
// gives one result, shown on the result ports for one cycle with done high.
// done is registered and rises at the edge that ends ST_LOOKUP. A hit gives
// no result. There is no backpressure: the receiver must take every result
// as it appears. The sender ends the text with '$' to flush the last phrase.
module lz78_phrase_encoder
    import lz78e_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [BYTE_W-1:0]   symbol_byte,
    output logic                done,
    output logic [PREFIX_W-1:0] prefix_number,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                dict_full,
    output logic                bad_symbol
);

    enc_state_t          state_reg, state_next;
    logic [NODE_W-1:0]   cur_node_reg, cur_node_next;
    logic [NEXT_W-1:0]   next_node_reg, next_node_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                bad_reg, bad_next;
    logic                done_reg, done_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                full_reg, full_next;
    logic                bad_out_reg, bad_out_next;

    mem_req_t            mem_req;
    logic [NODE_W-1:0]   child;
    logic                mem_ready;
    slot_info_t          slot_info;
    logic [ADDR_W-1:0]   lookup_addr;
    logic                accept;
    logic                is_full;

    lz78e_child_table u_child_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (child),
        .ready   (mem_ready)
    );

    assign slot_info   = slot_of(symbol_byte);
    assign lookup_addr = ADDR_W'(cur_node_reg) * ADDR_W'(ALPHABET) + ADDR_W'(slot_info.slot);
    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign is_full     = (next_node_reg >= NEXT_W'(DICT_NODES));

    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        next_node_next  = next_node_reg;
        addr_next       = addr_reg;
        byte_next       = byte_reg;
        bad_next        = bad_reg;
        done_next       = 1'b0;
        prefix_next     = prefix_reg;
        out_byte_next   = out_byte_reg;
        full_next       = full_reg;
        bad_out_next    = bad_out_reg;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.addr    = lookup_addr;
        mem_req.wr_data = NODE_W'(next_node_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (mem_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_req.rd_en = 1'b1;
                    addr_next     = lookup_addr;
                    byte_next     = symbol_byte;
                    bad_next      = slot_info.slot_bad;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                mem_req.addr = addr_reg;
                state_next   = ST_IDLE;
                if (child != '0)
                begin
                    cur_node_next = child;
                end
                else
                begin
                    if (!is_full)
                    begin
                        mem_req.wr_en  = 1'b1;
                        next_node_next = next_node_reg + 1'b1;
                    end
                    cur_node_next = '0;
                    done_next     = 1'b1;
                    prefix_next   = PREFIX_W'(cur_node_reg);
                    out_byte_next = byte_reg;
                    full_next     = is_full;
                    bad_out_next  = bad_reg;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_node_reg  <= '0;
            next_node_reg <= NEXT_W'(1);
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_node_reg  <= cur_node_next;
            next_node_reg <= next_node_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        byte_reg     <= byte_next;
        prefix_reg   <= prefix_next;
        out_byte_reg <= out_byte_next;
        full_reg     <= full_next;
        bad_out_reg  <= bad_out_next;
        bad_reg      <= bad_next;
    end

    assign done          = done_reg;
    assign prefix_number = prefix_reg;
    assign out_byte      = out_byte_reg;
    assign dict_full     = full_reg;
    assign bad_symbol    = bad_out_reg;

`ifndef SYNTHESIS
    a_accept_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted request did not enter lookup");

    a_result_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |=> cur_node_reg == '0)
        else $error("walk not back at root after a result");

    a_next_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_node_reg >= NEXT_W'(1) && next_node_reg <= NEXT_W'(DICT_NODES))
        else $error("next node out of range");

    a_store_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> state_reg == ST_LOOKUP && child == '0 && done_next)
        else $error("node stored without a miss");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_next && is_full |=> dict_full && next_node_reg == NEXT_W'(DICT_NODES))
        else $error("full result with inconsistent node count");
`endif

endmodule
